// File: hdl/smm_pkg.sv
`timescale 1ns / 1ps
package smm_pkg;

   localparam int MAX_DIM_DEF    = 8;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int ELEM_W         = 32;
   localparam int SIZE_W         = 4;
   localparam int CSR_IDX_W      = 2;
   localparam int POS_W          = 3;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

   // item actions
   localparam logic [1:0] ACT_WRITE_A = 2'd0;
   localparam logic [1:0] ACT_WRITE_B = 2'd1;
   localparam logic [1:0] ACT_COMPUTE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B     = 2'd2;

   typedef struct packed {
      logic [1:0]              action;
      logic [POS_W-1:0]        row_index;
      logic [POS_W-1:0]        col_index;
      logic signed [ELEM_W-1:0] element_value;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]         out_row;
      logic [POS_W-1:0]         out_col;
      logic signed [ELEM_W-1:0] product_value;
      logic                     last_flag;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_READ  = 2'd1,
      ST_DRAIN = 2'd2
   } seq_state_type;

   typedef struct packed {
      logic issue;
      logic clear;
   } mac_ctrl_type;

endpackage

// File: hdl/strassen_matrix_multiply.sv
`timescale 1ns / 1ps
// Matrix product engine: elements of A (rows_a x inner_size) and B (inner_size x cols_b)
// are written one per item into two on-chip RAMs; a compute
// item then returns C = A * B row by row, one result item per element, last_flag on the
// final one, with sums wrapping modulo 2^DATA_WIDTH (the same answer a Strassen recursion
// gives). Entries beyond the configured sizes count as zero; size registers read 0 as 1
// and clamp above MAX_DIM. For each result element of a compute item, the products over
// the inner size are read in turn through the single read port of each RAM into one
// multiplier, and the read, multiply and accumulate stages drain before the sum is output;
// no new item is accepted until the last result is in the output register.
// The RAMs are not cleared after reset, so every element used must be written first.
// The user must write size registers only while no compute is running; the block does not enforce it.
module strassen_matrix_multiply import smm_pkg::*; #(
   parameter int MAX_DIM    = MAX_DIM_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_wdata
);

   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int STORE_W = (DATA_WIDTH < ELEM_W) ? DATA_WIDTH : ELEM_W;

   logic                  a_wr_en;
   logic                  b_wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [STORE_W-1:0]    wr_data;
   logic [ADDR_W-1:0]     a_rd_addr;
   logic [ADDR_W-1:0]     b_rd_addr;
   logic [STORE_W-1:0]    a_rd_data;
   logic [STORE_W-1:0]    b_rd_data;
   mac_ctrl_type          mac_ctrl;
   logic                  mac_busy;
   logic [DATA_WIDTH-1:0] acc;

   smm_seq #(
      .MAX_DIM    (MAX_DIM),
      .DATA_WIDTH (DATA_WIDTH),
      .STORE_W    (STORE_W)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .a_wr_en      (a_wr_en),
      .b_wr_en      (b_wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .a_rd_addr    (a_rd_addr),
      .b_rd_addr    (b_rd_addr),
      .mac_ctrl     (mac_ctrl),
      .mac_busy     (mac_busy),
      .acc          (acc)
   );

   smm_ram #(
      .WIDTH (STORE_W),
      .DEPTH (DEPTH)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   smm_ram #(
      .WIDTH (STORE_W),
      .DEPTH (DEPTH)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   smm_mac #(
      .DATA_WIDTH (DATA_WIDTH),
      .STORE_W    (STORE_W)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .mac_ctrl (mac_ctrl),
      .a_data   (a_rd_data),
      .b_data   (b_rd_data),
      .mac_busy (mac_busy),
      .acc      (acc)
   );

endmodule

// File: hdl/smm_ram.sv
`timescale 1ns / 1ps
module smm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/smm_mac.sv
`timescale 1ns / 1ps
module smm_mac import smm_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int STORE_W    = ELEM_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mac_ctrl_type          mac_ctrl,
   input  logic [STORE_W-1:0]    a_data,
   input  logic [STORE_W-1:0]    b_data,
   output logic                  mac_busy,
   output logic [DATA_WIDTH-1:0] acc
);

   logic                    data_vld_ff;
   logic                    prod_vld_ff;
   logic [DATA_WIDTH-1:0]   prod_ff;
   logic [DATA_WIDTH-1:0]   prod_in;
   logic [DATA_WIDTH-1:0]   acc_ff;
   logic [DATA_WIDTH-1:0]   acc_in;
   logic signed [2*STORE_W-1:0] full_prod;

   // product of sign-extended elements, only the low bits survive the wrap
   assign full_prod = $signed(a_data) * $signed(b_data);
   assign prod_in   = full_prod[DATA_WIDTH-1:0];

   always_comb begin
      acc_in = acc_ff;
      if (mac_ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_vld_ff <= 1'b0;
         prod_vld_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         data_vld_ff <= mac_ctrl.issue;
         prod_vld_ff <= data_vld_ff;
         acc_ff      <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mac_busy = data_vld_ff | prod_vld_ff;
   assign acc      = acc_ff;

   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      !(mac_ctrl.clear && prod_vld_ff))
      else $error("accumulator cleared while a product is pending");

   a_issue_reaches_acc: assert property (@(posedge clock) disable iff (reset)
      mac_ctrl.issue |=> ##1 prod_vld_ff)
      else $error("issued read did not reach the product stage");

endmodule

// File: hdl/smm_seq.sv
`timescale 1ns / 1ps
module smm_seq import smm_pkg::*; #(
   parameter int MAX_DIM    = MAX_DIM_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int STORE_W    = ELEM_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [SIZE_W-1:0]        csr_wdata,
   output logic                     a_wr_en,
   output logic                     b_wr_en,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] wr_addr,
   output logic [STORE_W-1:0]       wr_data,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] a_rd_addr,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] b_rd_addr,
   output mac_ctrl_type             mac_ctrl,
   input  logic                     mac_busy,
   input  logic [DATA_WIDTH-1:0]    acc
);

   localparam int IDX_W  = $clog2(MAX_DIM);
   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
   localparam logic [SIZE_W-1:0] DIM_S = SIZE_W'(MAX_DIM);
   localparam logic [ADDR_W-1:0] DIM_A = ADDR_W'(MAX_DIM);

   seq_state_type     state_ff, state_in;
   logic [SIZE_W-1:0] rows_a_ff, rows_a_in;
   logic [SIZE_W-1:0] inner_ff, inner_in;
   logic [SIZE_W-1:0] cols_b_ff, cols_b_in;
   logic [IDX_W-1:0]  nr_last_ff, nr_last_in;
   logic [IDX_W-1:0]  nk_last_ff, nk_last_in;
   logic [IDX_W-1:0]  nc_last_ff, nc_last_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [IDX_W-1:0]  t_ff, t_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              req_fire;
   logic              start_run;
   logic              load_out;
   logic              run_done;
   logic              in_range;
   logic [DATA_WIDTH+ELEM_W-1:0] acc_ext;

   // size register to last index, 0 acts as 1 and oversize as the maximum
   function automatic logic [IDX_W-1:0] last_of(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] c;
      c = v;
      if (v == '0) begin
         c = SIZE_W'(1);
      end else if (v > DIM_S) begin
         c = DIM_S;
      end
      c = c - SIZE_W'(1);
      return c[IDX_W-1:0];
   endfunction

   assign req_fire  = req_valid && req_ready;
   assign start_run = req_fire && (req_data.action == ACT_COMPUTE);
   assign run_done  = (i_ff == nr_last_ff) && (j_ff == nc_last_ff);
   assign in_range  = ({1'b0, req_data.row_index} < DIM_S)
                   && ({1'b0, req_data.col_index} < DIM_S);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_run) state_in = ST_READ;
         end
         ST_READ: begin
            if (t_ff == nk_last_ff) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (load_out) state_in = run_done ? ST_IDLE : ST_READ;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready      = 1'b0;
      mac_ctrl.issue = 1'b0;
      load_out       = 1'b0;
      case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_READ:  mac_ctrl.issue = 1'b1;
         ST_DRAIN: load_out = !mac_busy && (!rsp_valid_ff || rsp_ready);
         default: begin
            req_ready = 1'b0;
         end
      endcase
      mac_ctrl.clear = load_out;
   end

   // memory write side, only while idle
   always_comb begin
      a_wr_en = req_fire && in_range && (req_data.action == ACT_WRITE_A);
      b_wr_en = req_fire && in_range && (req_data.action == ACT_WRITE_B);
      wr_addr = ADDR_W'(req_data.row_index) * DIM_A + ADDR_W'(req_data.col_index);
      wr_data = req_data.element_value[STORE_W-1:0];
   end

   assign a_rd_addr = ADDR_W'(i_ff) * DIM_A + ADDR_W'(t_ff);
   assign b_rd_addr = ADDR_W'(t_ff) * DIM_A + ADDR_W'(j_ff);

   assign acc_ext = {{ELEM_W{1'b0}}, acc};

   always_comb begin
      rows_a_in  = rows_a_ff;
      inner_in   = inner_ff;
      cols_b_in  = cols_b_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_ROWS_A:     rows_a_in = csr_wdata;
            CSR_INNER_SIZE: inner_in  = csr_wdata;
            CSR_COLS_B:     cols_b_in = csr_wdata;
            default: begin
               rows_a_in = rows_a_ff;
            end
         endcase
      end

      nr_last_in = nr_last_ff;
      nk_last_in = nk_last_ff;
      nc_last_in = nc_last_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      t_in       = t_ff;
      if (start_run) begin
         nr_last_in = last_of(rows_a_ff);
         nk_last_in = last_of(inner_ff);
         nc_last_in = last_of(cols_b_ff);
         i_in       = '0;
         j_in       = '0;
         t_in       = '0;
      end else if (state_ff == ST_READ && t_ff != nk_last_ff) begin
         t_in = t_ff + IDX_W'(1);
      end else if (load_out) begin
         t_in = '0;
         if (j_ff == nc_last_ff) begin
            j_in = '0;
            i_in = i_ff + IDX_W'(1);
         end else begin
            j_in = j_ff + IDX_W'(1);
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_out) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.out_row       = POS_W'(i_ff);
         rsp_data_in.out_col       = POS_W'(j_ff);
         rsp_data_in.product_value = acc_ext[ELEM_W-1:0];
         rsp_data_in.last_flag     = run_done;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_a_ff    <= SIZE_RESET;
         inner_ff     <= SIZE_RESET;
         cols_b_ff    <= SIZE_RESET;
         nr_last_ff   <= '0;
         nk_last_ff   <= '0;
         nc_last_ff   <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         t_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_a_ff    <= rows_a_in;
         inner_ff     <= inner_in;
         cols_b_ff    <= cols_b_in;
         nr_last_ff   <= nr_last_in;
         nk_last_ff   <= nk_last_in;
         nc_last_ff   <= nc_last_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         t_ff         <= t_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mac_busy)
      else $error("multiply pipeline busy while idle");

   a_start_reads: assert property (@(posedge clock) disable iff (reset)
      start_run |=> (state_ff == ST_READ) && (t_ff == '0) && (i_ff == '0) && (j_ff == '0))
      else $error("compute did not start at the first element");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (load_out && run_done) |=> (state_ff == ST_IDLE) && rsp_valid_ff
                                  && rsp_data_ff.last_flag)
      else $error("final element did not end the run");

   a_t_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (t_ff <= nk_last_ff))
      else $error("inner index beyond inner size");

endmodule
